// File: sv/kct_pkg.sv
`default_nettype none
package kct_pkg;

    localparam int FRAC_BITS = 24;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_TOO_CLOSE = 2'd1;
    localparam logic [1:0] ST_INIT     = 2'd2;
    localparam logic [1:0] ST_SINGULAR = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_H0  = 3'd0;
    localparam logic [2:0] CFG_H1  = 3'd1;
    localparam logic [2:0] CFG_R   = 3'd2;
    localparam logic [2:0] CFG_QAA = 3'd3;
    localparam logic [2:0] CFG_QAR = 3'd4;
    localparam logic [2:0] CFG_QRR = 3'd5;
    localparam logic [2:0] CFG_GAP = 3'd6;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_INIT    = 1'b1;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_ADD = 2'd1,
        ALU_SUB = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic               opcode;
        logic [47:0]        sample_time;
        logic signed [31:0] value;
        logic signed [31:0] init_rate;
        logic [30:0]        init_cov_aa;
        logic signed [31:0] init_cov_ar;
        logic [30:0]        init_cov_rr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] angle_est;
        logic signed [31:0] rate_est;
    } out_item_t;

endpackage
`default_nettype wire

// File: sv/kalman_cv_tracker_2state_core.sv
`default_nettype none
// An init's result is registered at acceptance; a too-close measure goes through S_GAP to
// S_OUT and a singular innovation ends at step 20 of the sequence; a full update is paced
// by the two passes through the bit-serial divider and the 35-step sequence on the shared
// multiply/add unit.
// Throughput: one transaction at a time; s_ready is low until the result is taken.
// Reset (aresetn low, synchronous): state, covariance, last time cleared; config at defaults.
module kalman_cv_tracker_2state_core #(
    parameter int DATA_WIDTH = 32,
    parameter int TIME_WIDTH = 48
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire kct_pkg::in_item_t s_data,
    output logic m_valid,
    input  wire logic m_ready,
    output kct_pkg::out_item_t m_data
);
    localparam int DW = DATA_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE, S_GAP, S_SEQ, S_DIV0, S_DIV1, S_OUT
    } state_t;

    // Scratch register file slots.
    localparam logic [4:0] R_A=5'd0, R_T00=5'd1, R_T10=5'd2, R_PAA=5'd3, R_PAR=5'd4,
        R_PRR=5'd5, R_U0=5'd6, R_U1=5'd7, R_S=5'd8, R_K0=5'd9, R_K1=5'd10, R_Y=5'd11,
        R_X=5'd12, R_DT=5'd13, R_Z=5'd14, R_H0=5'd15, R_H1=5'd16, R_R=5'd17,
        R_QAA=5'd18, R_QAR=5'd19, R_QRR=5'd20, R_ANG=5'd21, R_RATE=5'd22,
        R_CAA=5'd23, R_CAR=5'd24, R_CRR=5'd25, R_X2=5'd26;
    localparam int NREG = 27;
    localparam int NSTEP = 34;

    // Configuration registers.
    logic signed [31:0] h0_reg, h1_reg, qar_reg;
    logic [30:0] r_reg, qaa_reg, qrr_reg;
    logic [15:0] gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h0_reg <= 32'sd16777216; h1_reg <= '0; r_reg <= 31'd16777;
            qaa_reg <= '0; qar_reg <= '0; qrr_reg <= '0; gap_reg <= 16'd52;
        end else if (cfg_we) begin
            case (cfg_index)
                kct_pkg::CFG_H0:  h0_reg  <= cfg_data;
                kct_pkg::CFG_H1:  h1_reg  <= cfg_data;
                kct_pkg::CFG_R:   r_reg   <= cfg_data[30:0];
                kct_pkg::CFG_QAA: qaa_reg <= cfg_data[30:0];
                kct_pkg::CFG_QAR: qar_reg <= cfg_data;
                kct_pkg::CFG_QRR: qrr_reg <= cfg_data[30:0];
                kct_pkg::CFG_GAP: gap_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [DW-1:0] ext32(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (DW >= 32) return DW'(w);
        if (w > 64'(DMAX)) return DMAX;
        if (w < -64'(DMAX) - 64'sd1) return ~DMAX;
        return DW'(w);
    endfunction

    function automatic logic signed [DW-1:0] ext31(input logic [30:0] v);
        logic signed [63:0] w;
        w = 64'({33'd0, v});
        if (w > 64'(DMAX)) return DMAX;
        return DW'(w);
    endfunction

    // Micro-program: op, destination, source a, source b.
    typedef struct packed {
        kct_pkg::alu_op_t op;
        logic [4:0] d;
        logic [4:0] a;
        logic [4:0] b;
    } uop_t;

    function automatic uop_t prog(input logic [5:0] i);
        case (i)
            6'd0:  return '{kct_pkg::ALU_MUL, R_X,   R_DT,  R_RATE};
            6'd1:  return '{kct_pkg::ALU_ADD, R_A,   R_ANG, R_X};
            6'd2:  return '{kct_pkg::ALU_MUL, R_X,   R_CAR, R_DT};
            6'd3:  return '{kct_pkg::ALU_ADD, R_T00, R_CAA, R_X};
            6'd4:  return '{kct_pkg::ALU_MUL, R_X,   R_CRR, R_DT};
            6'd5:  return '{kct_pkg::ALU_ADD, R_T10, R_CAR, R_X};
            6'd6:  return '{kct_pkg::ALU_MUL, R_X,   R_DT,  R_T10};
            6'd7:  return '{kct_pkg::ALU_ADD, R_X,   R_T00, R_X};
            6'd8:  return '{kct_pkg::ALU_ADD, R_PAA, R_X,   R_QAA};
            6'd9:  return '{kct_pkg::ALU_ADD, R_PAR, R_T10, R_QAR};
            6'd10: return '{kct_pkg::ALU_ADD, R_PRR, R_CRR, R_QRR};
            6'd11: return '{kct_pkg::ALU_MUL, R_X,   R_PAA, R_H0};
            6'd12: return '{kct_pkg::ALU_MUL, R_X2,  R_PAR, R_H1};
            6'd13: return '{kct_pkg::ALU_ADD, R_U0,  R_X,   R_X2};
            6'd14: return '{kct_pkg::ALU_MUL, R_X,   R_PAR, R_H0};
            6'd15: return '{kct_pkg::ALU_MUL, R_X2,  R_PRR, R_H1};
            6'd16: return '{kct_pkg::ALU_ADD, R_U1,  R_X,   R_X2};
            6'd17: return '{kct_pkg::ALU_MUL, R_X,   R_H0,  R_U0};
            6'd18: return '{kct_pkg::ALU_MUL, R_X2,  R_H1,  R_U1};
            6'd19: return '{kct_pkg::ALU_ADD, R_X,   R_X,   R_X2};
            6'd20: return '{kct_pkg::ALU_ADD, R_S,   R_X,   R_R};
            // Divisions happen between step 20 and step 21.
            6'd21: return '{kct_pkg::ALU_MUL, R_X,   R_H0,  R_A};
            6'd22: return '{kct_pkg::ALU_MUL, R_X2,  R_H1,  R_RATE};
            6'd23: return '{kct_pkg::ALU_ADD, R_X,   R_X,   R_X2};
            6'd24: return '{kct_pkg::ALU_SUB, R_Y,   R_Z,   R_X};
            6'd25: return '{kct_pkg::ALU_MUL, R_X,   R_K0,  R_Y};
            6'd26: return '{kct_pkg::ALU_ADD, R_ANG, R_A,   R_X};
            6'd27: return '{kct_pkg::ALU_MUL, R_X,   R_K1,  R_Y};
            6'd28: return '{kct_pkg::ALU_ADD, R_RATE, R_RATE, R_X};
            6'd29: return '{kct_pkg::ALU_MUL, R_X,   R_K0,  R_U0};
            6'd30: return '{kct_pkg::ALU_SUB, R_CAA, R_PAA, R_X};
            6'd31: return '{kct_pkg::ALU_MUL, R_X,   R_K0,  R_U1};
            6'd32: return '{kct_pkg::ALU_SUB, R_CAR, R_PAR, R_X};
            6'd33: return '{kct_pkg::ALU_MUL, R_X,   R_K1,  R_U1};
            default: return '{kct_pkg::ALU_SUB, R_CRR, R_PRR, R_X};
        endcase
    endfunction

    state_t state_reg;
    logic signed [DW-1:0] rf_reg [NREG];
    logic [TW-1:0] last_time_reg, time_reg;
    logic [TW-1:0] ticks_reg;
    logic [5:0] pc_reg;
    logic [1:0] status_reg;
    logic m_valid_reg;
    uop_t uop;
    logic signed [DW-1:0] alu_y;
    logic div_start, div_done;
    logic signed [DW-1:0] div_num, div_den, div_q;
    logic [TW-1:0] t_in;
    logic [TW+3:0] dt_wide;

    assign uop = prog(pc_reg);
    assign t_in = TW'(s_data.sample_time);

    kct_alu #(.DW(DW)) u_alu (
        .op(uop.op), .a(rf_reg[uop.a]), .b(rf_reg[uop.b]), .y(alu_y)
    );

    kct_div #(.DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    // Divisions are launched on entering each divide state.
    // The first one takes S straight from the unit, as it is stored at the same edge.
    assign div_start = (state_reg == S_SEQ && pc_reg == 6'd20 && alu_y > 0) ||
                       (state_reg == S_DIV0 && div_done);
    assign div_num = (state_reg == S_DIV0) ? rf_reg[R_U1] : rf_reg[R_U0];
    assign div_den = (state_reg == S_DIV0) ? rf_reg[R_S] : alu_y;
    assign dt_wide = {ticks_reg, 4'b0000};

    // Sequencer and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            last_time_reg <= '0;
            pc_reg        <= '0;
            rf_reg[R_ANG] <= '0; rf_reg[R_RATE] <= '0;
            rf_reg[R_CAA] <= '0; rf_reg[R_CAR] <= '0; rf_reg[R_CRR] <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_data.opcode == kct_pkg::OP_INIT) begin
                            rf_reg[R_ANG]  <= ext32(s_data.value);
                            rf_reg[R_RATE] <= ext32(s_data.init_rate);
                            rf_reg[R_CAA]  <= ext31(s_data.init_cov_aa);
                            rf_reg[R_CAR]  <= ext32(s_data.init_cov_ar);
                            rf_reg[R_CRR]  <= ext31(s_data.init_cov_rr);
                            last_time_reg  <= t_in;
                            status_reg     <= kct_pkg::ST_INIT;
                            m_valid_reg    <= 1'b1;
                            state_reg      <= S_OUT;
                        end else begin
                            time_reg  <= t_in;
                            ticks_reg <= (t_in >= last_time_reg) ? t_in - last_time_reg
                                                                 : last_time_reg - t_in;
                            rf_reg[R_Z]   <= ext32(s_data.value);
                            rf_reg[R_H0]  <= ext32(h0_reg);
                            rf_reg[R_H1]  <= ext32(h1_reg);
                            rf_reg[R_R]   <= ext31(r_reg);
                            rf_reg[R_QAA] <= ext31(qaa_reg);
                            rf_reg[R_QAR] <= ext32(qar_reg);
                            rf_reg[R_QRR] <= ext31(qrr_reg);
                            state_reg <= S_GAP;
                        end
                    end
                end
                S_GAP: begin
                    if (ticks_reg <= TW'(gap_reg)) begin
                        status_reg  <= kct_pkg::ST_TOO_CLOSE;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        if (dt_wide > (TW+4)'(DMAX)) rf_reg[R_DT] <= DMAX;
                        else rf_reg[R_DT] <= DW'(dt_wide);
                        pc_reg    <= '0;
                        state_reg <= S_SEQ;
                    end
                end
                S_SEQ: begin
                    rf_reg[uop.d] <= alu_y;
                    if (pc_reg == 6'd20) begin
                        if (alu_y > 0) begin
                            state_reg <= S_DIV0;
                        end else begin
                            status_reg  <= kct_pkg::ST_SINGULAR;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                    end else if (pc_reg == 6'(NSTEP)) begin
                        last_time_reg <= time_reg;
                        status_reg    <= kct_pkg::ST_UPDATED;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    pc_reg <= pc_reg + 1'b1;
                end
                S_DIV0: begin
                    if (div_done) begin
                        rf_reg[R_K0] <= div_q;
                        state_reg    <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        rf_reg[R_K1] <= div_q;
                        state_reg    <= S_SEQ;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Results are sign-extended or truncated to the 32-bit port fields.
    always_comb begin
        m_data.status    = status_reg;
        m_data.angle_est = 32'(rf_reg[R_ANG]);
        m_data.rate_est  = 32'(rf_reg[R_RATE]);
    end
endmodule
`default_nettype wire

// File: sv/kct_alu.sv
`default_nettype none
// Shared saturating Q-format multiply, add and subtract unit.
module kct_alu #(
    parameter int DW = 32
) (
    input  wire kct_pkg::alu_op_t op,
    input  wire logic signed [DW-1:0] a,
    input  wire logic signed [DW-1:0] b,
    output logic signed [DW-1:0] y
);
    localparam logic signed [DW:0] DMAX_W = {2'b00, {(DW-1){1'b1}}};
    localparam logic signed [DW:0] DMIN_W = {2'b11, {(DW-1){1'b0}}};
    localparam logic signed [2*DW-1:0] PMAX = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [2*DW-1:0] PMIN = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [2*DW-1:0] prod;
    logic signed [2*DW-1:0] prod_sh;
    logic signed [DW:0]     sum;

    always_comb begin
        prod    = a * b;
        prod_sh = prod >>> kct_pkg::FRAC_BITS;
        sum     = (op == kct_pkg::ALU_SUB) ? ({a[DW-1], a} - {b[DW-1], b})
                                           : ({a[DW-1], a} + {b[DW-1], b});
        case (op)
            kct_pkg::ALU_MUL: begin
                if (prod_sh > PMAX) y = PMAX[DW-1:0];
                else if (prod_sh < PMIN) y = PMIN[DW-1:0];
                else y = prod_sh[DW-1:0];
            end
            default: begin
                if (sum > DMAX_W) y = DMAX_W[DW-1:0];
                else if (sum < DMIN_W) y = DMIN_W[DW-1:0];
                else y = sum[DW-1:0];
            end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/kct_div.sv
`default_nettype none
// Restoring divider: (num * 2^FRAC) / den, truncated toward zero, saturated.
// One quotient bit per cycle; den is positive.
module kct_div #(
    parameter int DW = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic signed [DW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic done,
    output logic signed [DW-1:0] quot
);
    localparam int NW = DW + kct_pkg::FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] QMAX = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [NW-1:0] QMIN_MAG = {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic [NW-1:0] dividend_reg, dividend_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW-1:0] mag;
    logic [DW-1:0] qpos;

    always_comb begin
        dividend_next = dividend_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        mag           = num[DW-1] ? (~num + 1'b1) : num;
        trial         = {rem_reg[DW-1:0], dividend_reg[NW-1]};
        if (start) begin
            dividend_next = {mag, {kct_pkg::FRAC_BITS{1'b0}}};
            q_next        = '0;
            rem_next      = '0;
            den_next      = den;
            neg_next      = num[DW-1];
            cnt_next      = CW'(NW);
            busy_next     = 1'b1;
        end else if (busy_reg) begin
            dividend_next = {dividend_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dividend_reg <= dividend_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
    end

    // A positive quotient saturates at DMAX, a negative one at DMIN.
    always_comb begin
        if (neg_reg) begin
            qpos = (q_reg > QMIN_MAG) ? QMIN_MAG[DW-1:0] : q_reg[DW-1:0];
            quot = ~qpos + 1'b1;
        end else begin
            qpos = (q_reg > QMAX) ? QMAX[DW-1:0] : q_reg[DW-1:0];
            quot = qpos;
        end
    end
    assign done = done_reg;
endmodule
`default_nettype wire
